// ===== rtl/lpi_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Line / plane intersection package
// Shared widths and the word types that pass between the pipeline sections.
// ============================================================================
package lpi_pkg;

    localparam int CW    = 32;          // coordinate width
    localparam int FB    = 16;          // fraction bits
    localparam int NW    = FB + 2;      // normal component width
    localparam int THR_W = 16;          // parallel threshold width
    localparam int TW    = CW + 2;      // one signed product term
    localparam int DW    = TW + 2;      // signed dot product / numerator
    localparam int PW    = 2 * CW - FB; // shifted point product magnitude

    typedef struct packed {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] sz;
        logic signed [CW-1:0] wx;
        logic signed [CW-1:0] wy;
        logic signed [CW-1:0] wz;
    } geo_t;

    // Division request: magnitudes of numerator and denominator.
    typedef struct packed {
        logic [DW-1:0] num_mag;
        logic [DW-1:0] dn_mag;
        logic          neg;
        logic          hit;
        geo_t          geo;
    } quo_req_t;

    // Division result: the saturated line parameter.
    typedef struct packed {
        logic signed [CW-1:0] t;
        logic                 hit;
        logic                 ovf;
        geo_t                 geo;
    } quo_res_t;

endpackage

// ===== rtl/lpi_dot.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Dot product section
// Forms w.n and s.n + d in three stages and decides whether the line is parallel.
// ============================================================================
module lpi_dot
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [lpi_pkg::NW-1:0]     nx,
    input  logic signed [lpi_pkg::NW-1:0]     ny,
    input  logic signed [lpi_pkg::NW-1:0]     nz,
    input  logic signed [lpi_pkg::CW-1:0]     d,
    input  lpi_pkg::geo_t                     geo,
    input  logic [lpi_pkg::THR_W-1:0]         thr,
    output logic                              out_valid,
    input  logic                              out_ready,
    output lpi_pkg::quo_req_t                 out_word
);

    // Product of a coordinate and a normal component, magnitude truncated.
    function automatic logic signed [lpi_pkg::TW-1:0] mulq
    (
        input logic signed [lpi_pkg::CW-1:0] a,
        input logic signed [lpi_pkg::NW-1:0] n
    );
        logic [lpi_pkg::CW-1:0]         ma;
        logic [lpi_pkg::NW-1:0]         mn;
        logic [lpi_pkg::CW+lpi_pkg::NW-1:0] p;
        logic [lpi_pkg::TW-1:0]         sh;
        ma = a[lpi_pkg::CW-1] ? (~a + 1'b1) : a;
        mn = n[lpi_pkg::NW-1] ? (~n + 1'b1) : n;
        p  = (lpi_pkg::CW+lpi_pkg::NW)'(ma) * (lpi_pkg::CW+lpi_pkg::NW)'(mn);
        sh = lpi_pkg::TW'(p >> lpi_pkg::FB);
        return (a[lpi_pkg::CW-1] ^ n[lpi_pkg::NW-1]) ? -$signed(sh) : $signed(sh);
    endfunction

    logic signed [lpi_pkg::TW-1:0] tdn_reg [3];
    logic signed [lpi_pkg::TW-1:0] tnum_reg [3];
    logic signed [lpi_pkg::CW-1:0] d0_reg;
    lpi_pkg::geo_t                 geo0_reg;
    logic                          v0_reg;

    logic signed [lpi_pkg::DW-1:0] dn_reg;
    logic signed [lpi_pkg::DW-1:0] num_reg;
    lpi_pkg::geo_t                 geo1_reg;
    logic                          v1_reg;

    lpi_pkg::quo_req_t             out_reg;
    lpi_pkg::quo_req_t             out_next;
    logic                          v2_reg;

    logic                          rdy0;
    logic                          rdy1;
    logic                          rdy2;
    logic [lpi_pkg::DW-1:0]        dn_mag;
    logic [lpi_pkg::DW-1:0]        num_mag;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign in_ready = rdy0;

    always_comb
    begin
        dn_mag  = dn_reg[lpi_pkg::DW-1] ? (~dn_reg + 1'b1) : dn_reg;
        num_mag = num_reg[lpi_pkg::DW-1] ? (~num_reg + 1'b1) : num_reg;
        out_next.num_mag = num_mag;
        out_next.dn_mag  = dn_mag;
        out_next.neg     = (num_reg != '0) && (num_reg[lpi_pkg::DW-1] == dn_reg[lpi_pkg::DW-1]);
        out_next.hit     = (dn_reg != '0) &&
                           (dn_mag >= {{(lpi_pkg::DW-lpi_pkg::THR_W){1'b0}}, thr});
        out_next.geo     = geo1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= in_valid;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && in_valid)
        begin
            tdn_reg[0]  <= mulq(geo.wx, nx);
            tdn_reg[1]  <= mulq(geo.wy, ny);
            tdn_reg[2]  <= mulq(geo.wz, nz);
            tnum_reg[0] <= mulq(geo.sx, nx);
            tnum_reg[1] <= mulq(geo.sy, ny);
            tnum_reg[2] <= mulq(geo.sz, nz);
            d0_reg      <= d;
            geo0_reg    <= geo;
        end
        if (rdy1 && v0_reg)
        begin
            dn_reg   <= lpi_pkg::DW'(tdn_reg[0]) + lpi_pkg::DW'(tdn_reg[1]) +
                        lpi_pkg::DW'(tdn_reg[2]);
            num_reg  <= lpi_pkg::DW'(tnum_reg[0]) + lpi_pkg::DW'(tnum_reg[1]) +
                        lpi_pkg::DW'(tnum_reg[2]) + lpi_pkg::DW'(d0_reg);
            geo1_reg <= geo0_reg;
        end
        if (rdy2 && v1_reg)
            out_reg <= out_next;
    end

    assign out_valid = v2_reg;
    assign out_word  = out_reg;

endmodule

// ===== rtl/lpi_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Pipelined divider
// Restoring division, one quotient bit per stage, then saturation of t.
// ============================================================================
module lpi_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lpi_pkg::quo_req_t in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output lpi_pkg::quo_res_t out_word
);

    typedef struct packed {
        logic [lpi_pkg::DW-1:0] r;
        logic [lpi_pkg::CW-1:0] f;
        logic [lpi_pkg::CW-1:0] q;
        logic [lpi_pkg::DW-1:0] b;
        logic                   sat;
        logic                   neg;
        logic                   hit;
        lpi_pkg::geo_t          geo;
    } div_st_t;

    div_st_t           st_reg [lpi_pkg::CW+1];
    logic              v_reg [lpi_pkg::CW+1];
    logic              rdy [lpi_pkg::CW+2];
    lpi_pkg::quo_res_t fin_reg;
    lpi_pkg::quo_res_t fin_next;
    logic              fin_v_reg;
    div_st_t           st0_next;
    logic [lpi_pkg::CW-1:0] lim;
    logic [lpi_pkg::CW-1:0] qq;
    logic                   big;

    assign rdy[lpi_pkg::CW+1] = !fin_v_reg || out_ready;
    assign in_ready           = rdy[0];

    // The top quotient bits are zero unless the result saturates, so the
    // partial remainder starts at the upper part of the numerator.
    always_comb
    begin
        st0_next.r   = in_word.num_mag >> (lpi_pkg::CW - lpi_pkg::FB);
        st0_next.f   = lpi_pkg::CW'(in_word.num_mag) << lpi_pkg::FB;
        st0_next.q   = '0;
        st0_next.b   = in_word.dn_mag;
        st0_next.sat = (in_word.num_mag >> (lpi_pkg::CW - lpi_pkg::FB)) >= in_word.dn_mag;
        st0_next.neg = in_word.neg;
        st0_next.hit = in_word.hit;
        st0_next.geo = in_word.geo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (rdy[0])
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
            st_reg[0] <= st0_next;
    end

    assign rdy[0] = !v_reg[0] || rdy[1];

    for (genvar k = 1; k <= lpi_pkg::CW; k++)
    begin : g_bit
        logic [lpi_pkg::DW:0] r2;
        logic [lpi_pkg::DW:0] diff;
        logic                 take;
        div_st_t              nxt;

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_comb
        begin
            r2   = {st_reg[k-1].r, st_reg[k-1].f[lpi_pkg::CW-1]};
            diff = r2 - {1'b0, st_reg[k-1].b};
            take = r2 >= {1'b0, st_reg[k-1].b};
            nxt   = st_reg[k-1];
            nxt.r = take ? lpi_pkg::DW'(diff) : lpi_pkg::DW'(r2);
            nxt.f = st_reg[k-1].f << 1;
            nxt.q = {st_reg[k-1].q[lpi_pkg::CW-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (rdy[k])
                v_reg[k] <= v_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && v_reg[k-1])
                st_reg[k] <= nxt;
        end
    end

    always_comb
    begin
        lim = st_reg[lpi_pkg::CW].neg ? (lpi_pkg::CW'(1) << (lpi_pkg::CW-1))
                                       : ~(lpi_pkg::CW'(1) << (lpi_pkg::CW-1));
        big = st_reg[lpi_pkg::CW].sat || (st_reg[lpi_pkg::CW].q > lim);
        qq  = big ? lim : st_reg[lpi_pkg::CW].q;
        fin_next.t   = $signed(st_reg[lpi_pkg::CW].neg ? (~qq + 1'b1) : qq);
        fin_next.hit = st_reg[lpi_pkg::CW].hit;
        fin_next.ovf = st_reg[lpi_pkg::CW].hit && big;
        fin_next.geo = st_reg[lpi_pkg::CW].geo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_v_reg <= 1'b0;
        else if (rdy[lpi_pkg::CW+1])
            fin_v_reg <= v_reg[lpi_pkg::CW];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[lpi_pkg::CW+1] && v_reg[lpi_pkg::CW])
            fin_reg <= fin_next;
    end

    assign out_valid = fin_v_reg;
    assign out_word  = fin_reg;

endmodule

// ===== rtl/lpi_point.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Intersection point section
// Multiplies the direction by t, adds the start point and saturates.
// ============================================================================
module lpi_point
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lpi_pkg::quo_res_t             in_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit,
    output logic signed [lpi_pkg::CW-1:0] t_param,
    output logic signed [lpi_pkg::CW-1:0] hit_x,
    output logic signed [lpi_pkg::CW-1:0] hit_y,
    output logic signed [lpi_pkg::CW-1:0] hit_z,
    output logic                          overflow
);

    logic [2*lpi_pkg::CW-1:0]      pm_reg [3];
    logic                          sgn_reg [3];
    logic signed [lpi_pkg::CW-1:0] s_reg [3];
    logic signed [lpi_pkg::CW-1:0] t0_reg;
    logic                          hit0_reg;
    logic                          ovf0_reg;
    logic                          v0_reg;

    logic                          hit_reg;
    logic signed [lpi_pkg::CW-1:0] t_reg;
    logic signed [lpi_pkg::CW-1:0] p_reg [3];
    logic                          ovf_reg;
    logic                          v1_reg;

    logic signed [lpi_pkg::CW-1:0] w_in [3];
    logic signed [lpi_pkg::CW-1:0] s_in [3];
    logic [lpi_pkg::CW-1:0]        tm;
    logic [lpi_pkg::CW-1:0]        wm [3];
    logic [lpi_pkg::PW-1:0]        sh [3];
    logic signed [lpi_pkg::PW:0]   sv [3];
    logic signed [lpi_pkg::PW+1:0] sum [3];
    logic signed [lpi_pkg::CW-1:0] p_next [3];
    logic [2:0]                    sat;
    logic                          rdy0;
    logic                          rdy1;

    assign rdy1     = !v1_reg || out_ready;
    assign rdy0     = !v0_reg || rdy1;
    assign in_ready = rdy0;

    always_comb
    begin
        w_in[0] = in_word.geo.wx;
        w_in[1] = in_word.geo.wy;
        w_in[2] = in_word.geo.wz;
        s_in[0] = in_word.geo.sx;
        s_in[1] = in_word.geo.sy;
        s_in[2] = in_word.geo.sz;
        tm = in_word.t[lpi_pkg::CW-1] ? (~in_word.t + 1'b1) : in_word.t;
        for (int i = 0; i < 3; i++)
            wm[i] = w_in[i][lpi_pkg::CW-1] ? (~w_in[i] + 1'b1) : w_in[i];
    end

    // Saturate when the bits above the result width disagree with its sign.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sh[i]  = pm_reg[i][2*lpi_pkg::CW-1:lpi_pkg::FB];
            sv[i]  = sgn_reg[i] ? -$signed({1'b0, sh[i]}) : $signed({1'b0, sh[i]});
            sum[i] = (lpi_pkg::PW+2)'(s_reg[i]) + (lpi_pkg::PW+2)'(sv[i]);
            sat[i] = (sum[i][lpi_pkg::PW+1:lpi_pkg::CW-1] != '0) &&
                     (sum[i][lpi_pkg::PW+1:lpi_pkg::CW-1] != '1);
            if (sat[i])
                p_next[i] = sum[i][lpi_pkg::PW+1] ? $signed(lpi_pkg::CW'(1) << (lpi_pkg::CW-1))
                                                  : $signed(~(lpi_pkg::CW'(1) << (lpi_pkg::CW-1)));
            else
                p_next[i] = sum[i][lpi_pkg::CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= in_valid;
            if (rdy1)
                v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && in_valid)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pm_reg[i]  <= (2*lpi_pkg::CW)'(wm[i]) * (2*lpi_pkg::CW)'(tm);
                sgn_reg[i] <= w_in[i][lpi_pkg::CW-1] ^ in_word.t[lpi_pkg::CW-1];
                s_reg[i]   <= s_in[i];
            end
            t0_reg   <= in_word.t;
            hit0_reg <= in_word.hit;
            ovf0_reg <= in_word.ovf;
        end
        if (rdy1 && v0_reg)
        begin
            hit_reg <= hit0_reg;
            t_reg   <= hit0_reg ? t0_reg : '0;
            for (int i = 0; i < 3; i++)
                p_reg[i] <= hit0_reg ? p_next[i] : '0;
            ovf_reg <= hit0_reg && (ovf0_reg || (sat != 3'b000));
        end
    end

    assign out_valid = v1_reg;
    assign hit       = hit_reg;
    assign t_param   = t_reg;
    assign hit_x     = p_reg[0];
    assign hit_y     = p_reg[1];
    assign hit_z     = p_reg[2];
    assign overflow  = ovf_reg;

endmodule

// ===== rtl/line_plane_intersection_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Line / plane intersection core
// Fixed point Q16.16 intersection of a line with a plane, fully pipelined.
// ============================================================================
// Usage:
//   An input word carries the plane (normal and offset), the line start and
//   the line direction on the in_valid / in_ready channel. Each input word
//   yields exactly one result word on the out_valid / out_ready channel, in
//   order: the hit flag, the saturated line parameter t, the saturated
//   intersection point and the overflow flag. A parallel line gives hit low
//   and all other fields zero.
//   The configuration channel (cfg_valid / cfg_ready / cfg_data) writes the
//   parallel threshold; it is always ready and should be written only while
//   no word is in flight. Reset sets the threshold to 1.
//   The pipeline has three dot product stages, one divider setup stage, 32
//   restoring division stages (one quotient bit each), a saturation stage and
//   two point stages. A new word is accepted every cycle as long as no stall
//   fills the pipeline. Every stage has its own valid bit and holds only while the
//   stage after it is full, so a stalled receiver first lets the bubbles in
//   the pipeline fill, and in_ready drops only once every stage holds a word.
//   Reset empties the pipeline; no word is lost or repeated across a stall.
// ============================================================================
module line_plane_intersection_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lpi_pkg::THR_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [lpi_pkg::NW-1:0]        plane_nx,
    input  logic signed [lpi_pkg::NW-1:0]        plane_ny,
    input  logic signed [lpi_pkg::NW-1:0]        plane_nz,
    input  logic signed [lpi_pkg::CW-1:0]        plane_offset,
    input  logic signed [lpi_pkg::CW-1:0]        start_x,
    input  logic signed [lpi_pkg::CW-1:0]        start_y,
    input  logic signed [lpi_pkg::CW-1:0]        start_z,
    input  logic signed [lpi_pkg::CW-1:0]        dir_x,
    input  logic signed [lpi_pkg::CW-1:0]        dir_y,
    input  logic signed [lpi_pkg::CW-1:0]        dir_z,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 hit,
    output logic signed [lpi_pkg::CW-1:0]        t_param,
    output logic signed [lpi_pkg::CW-1:0]        hit_x,
    output logic signed [lpi_pkg::CW-1:0]        hit_y,
    output logic signed [lpi_pkg::CW-1:0]        hit_z,
    output logic                                 overflow
);

    // The threshold register is the only configuration state.
    logic [lpi_pkg::THR_W-1:0] thr_reg;
    lpi_pkg::geo_t             geo;
    lpi_pkg::quo_req_t         dq_word;
    logic                      dq_valid;
    logic                      dq_ready;
    lpi_pkg::quo_res_t         qr_word;
    logic                      qr_valid;
    logic                      qr_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= lpi_pkg::THR_W'(1);
        else if (cfg_valid && cfg_ready)
            thr_reg <= cfg_data;
    end

    always_comb
    begin
        geo.sx = start_x;
        geo.sy = start_y;
        geo.sz = start_z;
        geo.wx = dir_x;
        geo.wy = dir_y;
        geo.wz = dir_z;
    end

    // Dot products and the parallel decision.
    lpi_dot u_dot
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .nx        (plane_nx),
        .ny        (plane_ny),
        .nz        (plane_nz),
        .d         (plane_offset),
        .geo       (geo),
        .thr       (thr_reg),
        .out_valid (dq_valid),
        .out_ready (dq_ready),
        .out_word  (dq_word)
    );

    // t = -(s.n + d) / (w.n), one quotient bit per stage.
    lpi_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dq_valid),
        .in_ready  (dq_ready),
        .in_word   (dq_word),
        .out_valid (qr_valid),
        .out_ready (qr_ready),
        .out_word  (qr_word)
    );

    // Point s + w * t and the output register.
    lpi_point u_point
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (qr_valid),
        .in_ready  (qr_ready),
        .in_word   (qr_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hit       (hit),
        .t_param   (t_param),
        .hit_x     (hit_x),
        .hit_y     (hit_y),
        .hit_z     (hit_z),
        .overflow  (overflow)
    );

`ifndef ASSERT_OFF
    // A parallel result carries no parameter, no point and no overflow.
    a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (t_param == '0 && hit_x == '0 && hit_y == '0 &&
                                 hit_z == '0 && !overflow))
        else $error("parallel result with nonzero fields");

    // A word marked as a hit has a nonzero denominator at or above the threshold.
    a_hit_thr : assert property (@(posedge clk) disable iff (!rst_n)
        (dq_valid && dq_word.hit) |->
            (dq_word.dn_mag != '0 &&
             dq_word.dn_mag >= {{(lpi_pkg::DW-lpi_pkg::THR_W){1'b0}}, thr_reg}))
        else $error("hit with denominator below threshold");
`endif

endmodule

// ===== verif/line_plane_intersection_core_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Line / plane intersection core testbench
// Drives plane and line words through the core with random bursts and gaps
// while the receiver stalls on its own pattern. Every result word is checked
// field by field against a fixed point intersection calculation kept here.
// The parallel threshold is changed between phases, covering both extremes.
// ============================================================================
module line_plane_intersection_core_test;

    localparam int    CLK_HALF   = 6;
    localparam int    PIPE_DEPTH = 39;
    localparam bit [63:0] MUL_CAP = 64'd1 << 61;

    typedef struct {
        logic signed [lpi_pkg::NW-1:0] nx, ny, nz;
        logic signed [lpi_pkg::CW-1:0] d;
        logic signed [lpi_pkg::CW-1:0] sx, sy, sz;
        logic signed [lpi_pkg::CW-1:0] wx, wy, wz;
    } plane_item_t;

    typedef struct {
        logic                          hit;
        logic signed [lpi_pkg::CW-1:0] t;
        logic signed [lpi_pkg::CW-1:0] px, py, pz;
        logic                          ovf;
    } isect_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [lpi_pkg::THR_W-1:0]     cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic signed [lpi_pkg::NW-1:0] plane_nx = '0, plane_ny = '0, plane_nz = '0;
    logic signed [lpi_pkg::CW-1:0] plane_offset = '0;
    logic signed [lpi_pkg::CW-1:0] start_x = '0, start_y = '0, start_z = '0;
    logic signed [lpi_pkg::CW-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          hit;
    logic signed [lpi_pkg::CW-1:0] t_param, hit_x, hit_y, hit_z;
    logic                          overflow;

    plane_item_t item_feed_q[$];
    isect_t      isect_expect_q[$];
    plane_item_t cur_item;
    logic [lpi_pkg::THR_W-1:0] thresh_model = 16'd1;
    bit          hold_feed = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          err_cnt = 0;
    int          words_in = 0, words_out = 0;
    int          hit_cnt = 0, par_cnt = 0, ovf_cnt = 0;
    int unsigned cycle_cnt = 0;

    line_plane_intersection_core i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .plane_nx     (plane_nx),
        .plane_ny     (plane_ny),
        .plane_nz     (plane_nz),
        .plane_offset (plane_offset),
        .start_x      (start_x),
        .start_y      (start_y),
        .start_z      (start_z),
        .dir_x        (dir_x),
        .dir_y        (dir_y),
        .dir_z        (dir_z),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .t_param      (t_param),
        .hit_x        (hit_x),
        .hit_y        (hit_y),
        .hit_z        (hit_z),
        .overflow     (overflow)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Fixed point arithmetic of the intersection.
    // ------------------------------------------------------------------------

    function automatic logic [63:0] mag64(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Exact product, magnitude truncated by the fraction bits, capped.
    function automatic longint fix_mul(input longint a, input longint b);
        logic [127:0] p;
        longint       m;
        p = ({64'd0, mag64(a)} * {64'd0, mag64(b)}) >> lpi_pkg::FB;
        if (p > {64'd0, MUL_CAP})
            p = {64'd0, MUL_CAP};
        m = longint'(p[63:0]);
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic longint clamp_coord(input longint v, inout logic ovf);
        longint hi_lim, lo_lim;
        hi_lim = (longint'(1) <<< (lpi_pkg::CW - 1)) - 1;
        lo_lim = -hi_lim - 1;
        if (v > hi_lim)
        begin
            ovf = 1'b1;
            return hi_lim;
        end
        if (v < lo_lim)
        begin
            ovf = 1'b1;
            return lo_lim;
        end
        return v;
    endfunction

    function automatic isect_t predict_isect(input plane_item_t it,
                                             input logic [lpi_pkg::THR_W-1:0] thr);
        isect_t       r;
        longint       dn, num, t;
        logic [127:0] a, b, q, lim;
        logic         neg;
        r = '{default: '0};
        dn = fix_mul(it.wx, it.nx) + fix_mul(it.wy, it.ny) + fix_mul(it.wz, it.nz);
        // A zero dot product is parallel even with a zero threshold.
        if (dn == 0 || mag64(dn) < {48'd0, thr})
            return r;
        num = fix_mul(it.sx, it.nx) + fix_mul(it.sy, it.ny) + fix_mul(it.sz, it.nz)
              + longint'(it.d);
        a   = {64'd0, mag64(num)};
        b   = {64'd0, mag64(dn)};
        neg = (num != 0) && ((num < 0) == (dn < 0));
        lim = neg ? (128'd1 << (lpi_pkg::CW - 1)) : (128'd1 << (lpi_pkg::CW - 1)) - 1;
        q   = (a << lpi_pkg::FB) / b;
        if (q > lim)
        begin
            q = lim;
            r.ovf = 1'b1;
        end
        t = neg ? -longint'(q[63:0]) : longint'(q[63:0]);
        r.hit = 1'b1;
        r.t   = t[lpi_pkg::CW-1:0];
        r.px  = lpi_pkg::CW'(clamp_coord(longint'(it.sx) + fix_mul(it.wx, t), r.ovf));
        r.py  = lpi_pkg::CW'(clamp_coord(longint'(it.sy) + fix_mul(it.wy, t), r.ovf));
        r.pz  = lpi_pkg::CW'(clamp_coord(longint'(it.sz) + fix_mul(it.wz, t), r.ovf));
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: sends queued words in bursts of random length with random gaps.
    // The expected result is computed at the edge where a word is accepted,
    // using the threshold that is in force at that time.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                isect_expect_q.push_back(predict_isect(cur_item, thresh_model));
                words_in++;
            end
            // A new word may only be presented once the current one is gone.
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0 || hold_feed || item_feed_q.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    cur_item = item_feed_q.pop_front();
                    plane_nx     <= cur_item.nx;
                    plane_ny     <= cur_item.ny;
                    plane_nz     <= cur_item.nz;
                    plane_offset <= cur_item.d;
                    start_x      <= cur_item.sx;
                    start_y      <= cur_item.sy;
                    start_z      <= cur_item.sz;
                    dir_x        <= cur_item.wx;
                    dir_y        <= cur_item.wy;
                    dir_z        <= cur_item.wz;
                    in_valid     <= 1'b1;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 40);
                    burst_left--;
                    // Some bursts run straight into the next one with no gap.
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: the stall pattern steps in turn through always ready,
    // mostly ready, coin flip and long stall stretches.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (rst_n)
        begin
            case ((cycle_cnt >> 8) % 4)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                2:       out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= (cycle_cnt[5:4] != 2'd0);
            endcase
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH word %0d %s: got %0d, expected %0d", words_out, what, got, want);
        err_cnt++;
    endtask

    // Monitor: compares each accepted result word with the oldest expectation.
    always @(posedge clk)
    begin
        isect_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (isect_expect_q.size() == 0)
                report_mismatch("unexpected word, hit", hit, 0);
            else
            begin
                e = isect_expect_q.pop_front();
                if (hit !== e.hit)      report_mismatch("hit", hit, e.hit);
                if (t_param !== e.t)    report_mismatch("t_param", t_param, e.t);
                if (hit_x !== e.px)     report_mismatch("hit_x", hit_x, e.px);
                if (hit_y !== e.py)     report_mismatch("hit_y", hit_y, e.py);
                if (hit_z !== e.pz)     report_mismatch("hit_z", hit_z, e.pz);
                if (overflow !== e.ovf) report_mismatch("overflow", overflow, e.ovf);
                if (e.hit) hit_cnt++; else par_cnt++;
                if (e.ovf) ovf_cnt++;
            end
            words_out++;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    function automatic logic signed [lpi_pkg::CW-1:0] rnd_coord(input int bits);
        logic signed [lpi_pkg::CW-1:0] v;
        v = $urandom;
        if (bits < lpi_pkg::CW)
            v = v >>> (lpi_pkg::CW - bits);
        return v;
    endfunction

    function automatic plane_item_t mk_item(input int nx, input int ny, input int nz,
                                            input int d, input int sx, input int sy,
                                            input int sz, input int wx, input int wy,
                                            input int wz);
        plane_item_t it;
        it.nx = lpi_pkg::NW'(nx); it.ny = lpi_pkg::NW'(ny); it.nz = lpi_pkg::NW'(nz);
        it.d = d;
        it.sx = sx; it.sy = sy; it.sz = sz;
        it.wx = wx; it.wy = wy; it.wz = wz;
        return it;
    endfunction

    // Mostly plausible geometry with moderate coordinates, some nearly
    // parallel lines around the threshold, and some words of raw noise.
    function automatic plane_item_t rnd_item();
        plane_item_t it;
        int          kind;
        kind = $urandom_range(0, 9);
        it.d  = rnd_coord(26);
        it.sx = rnd_coord(26); it.sy = rnd_coord(26); it.sz = rnd_coord(26);
        it.wx = rnd_coord(22); it.wy = rnd_coord(22); it.wz = rnd_coord(22);
        it.nx = lpi_pkg::NW'($urandom_range(0, 65536) -
                             ($urandom_range(0, 1) ? 65536 : 0));
        it.ny = lpi_pkg::NW'(rnd_coord(16));
        it.nz = lpi_pkg::NW'(rnd_coord(14));
        if (kind < 2)
        begin
            // Direction almost in the plane: dn lands near the threshold.
            it.nx = 18'sd65536; it.ny = '0; it.nz = '0;
            it.wx = $signed($urandom_range(0, 140000)) - 70000;
        end
        else if (kind < 4)
        begin
            it.nx = lpi_pkg::NW'($urandom);
            it.ny = lpi_pkg::NW'($urandom);
            it.nz = lpi_pkg::NW'($urandom);
            it.d  = $urandom;
            it.sx = $urandom; it.sy = $urandom; it.sz = $urandom;
            it.wx = $urandom; it.wy = $urandom; it.wz = $urandom;
        end
        return it;
    endfunction

    task automatic queue_random(input int count);
        repeat (count) item_feed_q.push_back(rnd_item());
    endtask

    // Waits until every word has been sent and answered, plus the pipeline.
    task automatic wait_idle();
        while (item_feed_q.size() != 0 || in_valid || isect_expect_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 5) @(posedge clk);
    endtask

    task automatic write_thresh(input logic [lpi_pkg::THR_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        thresh_model = value;
        cfg_valid <= 1'b0;
    endtask

    localparam int PMAX = 32'h7FFFFFFF;
    localparam int PMIN = 32'h80000000;
    localparam int ONE  = 65536;

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words with the reset threshold.
        item_feed_q.push_back(mk_item(ONE, 0, 0, 0, ONE, 0, 0, ONE, 0, 0));
        item_feed_q.push_back(mk_item(0, 0, ONE, -5 * ONE, 0, 0, 0, 0, 0, ONE));
        item_feed_q.push_back(mk_item(0, ONE, 0, 3 * ONE, ONE, 2 * ONE, 0, 0, -ONE, 0));
        // Direction in the plane: parallel.
        item_feed_q.push_back(mk_item(ONE, 0, 0, ONE, 0, 0, 0, 0, ONE, ONE));
        // Numerator zero: t is zero, point is the start.
        item_feed_q.push_back(mk_item(ONE, 0, 0, 0, 0, 7 * ONE, 9, ONE, ONE, 0));
        // Tiny dn against a huge numerator: t saturates both ways.
        item_feed_q.push_back(mk_item(ONE, 0, 0, PMAX, 0, 0, 0, 1, 0, 0));
        item_feed_q.push_back(mk_item(ONE, 0, 0, PMAX, 0, 0, 0, -1, 0, 0));
        // Point saturation with moderate t.
        item_feed_q.push_back(mk_item(ONE, 0, 0, -ONE, 0, PMAX, PMIN, ONE, PMAX, PMIN));
        // Extremes of every field.
        item_feed_q.push_back(mk_item(-ONE, -ONE, -ONE, PMIN, PMIN, PMIN, PMIN,
                                      PMIN, PMIN, PMIN));
        item_feed_q.push_back(mk_item(131071, -131072, 131071, PMAX, PMAX, PMAX, PMAX,
                                      PMAX, PMAX, PMAX));
        item_feed_q.push_back(mk_item(-131072, 131071, -131072, PMIN, PMAX, PMIN, PMAX,
                                      PMIN, PMAX, PMIN));
        item_feed_q.push_back(mk_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        item_feed_q.push_back(mk_item(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        // dn of exactly one LSB: at the reset threshold, so a hit.
        item_feed_q.push_back(mk_item(ONE, 0, 0, ONE, 0, 0, 0, 1, 0, 0));
        queue_random(70);
        // Hold the sender back until the pipeline has fully drained once.
        while (words_in < 50)
            @(posedge clk);
        hold_feed = 1'b1;
        while (in_valid || isect_expect_q.size() != 0)
            @(posedge clk);
        hold_feed = 1'b0;
        queue_random(60);
        wait_idle();

        // Zero threshold: only an exactly zero dot product is parallel.
        write_thresh(16'd0);
        item_feed_q.push_back(mk_item(ONE, 0, 0, ONE, 0, 0, 0, 0, ONE, 0));
        item_feed_q.push_back(mk_item(ONE, 0, 0, ONE, 0, 0, 0, 1, 0, 0));
        item_feed_q.push_back(mk_item(ONE, ONE, 0, ONE, 0, 0, 0, ONE, -ONE, 0));
        queue_random(130);
        wait_idle();

        // Largest threshold: any dot product magnitude below 0xFFFF is parallel.
        write_thresh(16'hFFFF);
        item_feed_q.push_back(mk_item(ONE, 0, 0, ONE, 0, 0, 0, 65534, 0, 0));
        item_feed_q.push_back(mk_item(ONE, 0, 0, ONE, 0, 0, 0, 65535, 0, 0));
        item_feed_q.push_back(mk_item(ONE, 0, 0, ONE, 0, 0, 0, -65535, 0, 0));
        queue_random(130);
        wait_idle();

        write_thresh(16'($urandom));
        queue_random(70);
        wait_idle();

        write_thresh(16'd1);
        queue_random(60);
        wait_idle();

        $display("Covered %0d words: %0d hits, %0d parallel, %0d saturated.",
                 words_out, hit_cnt, par_cnt, ovf_cnt);
        $display("Thresholds run: reset value, zero, full scale and a random value.");
        if (err_cnt == 0 && isect_expect_q.size() == 0)
            $display("line_plane_intersection_core_test: done, clean");
        else
            $display("line_plane_intersection_core_test: done, errors");
        $finish;
    end

    // Safety net in case the handshake hangs.
    initial
    begin
        #(5ms);
        $display("Timeout with %0d words outstanding.", isect_expect_q.size());
        $display("line_plane_intersection_core_test: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lpi_pkg.sv
rtl/lpi_dot.sv
rtl/lpi_div.sv
rtl/lpi_point.sv
rtl/line_plane_intersection_core.sv
verif/line_plane_intersection_core_test.sv
